// ===== src/olst_pkg.sv =====
// Shared constants and types for the ordered list store.
// No dependencies; compiled first.
package olst_pkg;

  localparam int CAPACITY   = 64;
  localparam int ITEM_WIDTH = 32;

  localparam int CMD_W = 3;
  localparam int POS_W = 7;
  localparam int ST_W  = 3;

  localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND       = 3'd5;
  localparam logic [CMD_W-1:0] CMD_REMOVE_VAL = 3'd6;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [ST_W-1:0] ST_RANGE   = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_MISSING = 3'd4;

  // Broadcast controls from the sequencer to every cell.
  typedef struct packed {
    logic match_en;
    logic first_en;
    logic wr_en;
    logic shift_en;
  } cell_ctrl_t;

endpackage

// ===== src/olst_if.sv =====
// Valid/ready channel interfaces for commands and results.
// Depends on olst_pkg for default widths.
interface olst_cmd_if #(
  parameter int ITEM_W = olst_pkg::ITEM_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic [olst_pkg::CMD_W-1:0]     cmd;
  logic signed [olst_pkg::POS_W-1:0] position;
  logic [ITEM_W-1:0]              item_value;

  modport source(output valid, cmd, position, item_value, input ready);
  modport sink(input valid, cmd, position, item_value, output ready);
endinterface

interface olst_res_if #(
  parameter int ITEM_W = olst_pkg::ITEM_WIDTH,
  parameter int IDX_W  = $clog2(olst_pkg::CAPACITY),
  parameter int CNT_W  = $clog2(olst_pkg::CAPACITY + 1)
) ();
  logic                      valid;
  logic                      ready;
  logic [ITEM_W-1:0]         result_value;
  logic [IDX_W-1:0]          found_position;
  logic [olst_pkg::ST_W-1:0] status;
  logic [CNT_W-1:0]          list_length;

  modport source(output valid, result_value, found_position, status, list_length,
                 input ready);
  modport sink(input valid, result_value, found_position, status, list_length,
               output ready);
endinterface

// ===== src/olst_cell.sv =====
// One slot of the list: holds an item, compares it, and shifts from its upper neighbor.
// Depends on olst_pkg (cell_ctrl_t).
module olst_cell #(
  parameter int ITEM_W = 32,
  parameter int IDX_W  = 6,
  parameter int CNT_W  = 7,
  parameter int IDX    = 0
) (
  input  logic                 clk,
  input  olst_pkg::cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]     target,
  input  logic [CNT_W-1:0]     count,
  input  logic [ITEM_W-1:0]    item,
  input  logic [ITEM_W-1:0]    above_data,
  input  logic                 below_any,
  output logic [ITEM_W-1:0]    data,
  output logic [ITEM_W-1:0]    sel_data,
  output logic                 any_out,
  output logic                 first
);
  import olst_pkg::*;

  logic match;
  logic at_target;
  logic past_target;

  assign at_target   = (IDX_W'(IDX) == target);
  assign past_target = (IDX_W'(IDX) >= target);

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && at_target) begin
      data <= item;
    end else if (ctrl.shift_en && past_target) begin
      data <= above_data;
    end
  end

  // only occupied slots may match
  always_ff @(posedge clk) begin
    if (ctrl.match_en) begin
      match <= (data == item) && (CNT_W'(IDX) < count);
    end
    if (ctrl.first_en) begin
      first <= match && !below_any;
    end
  end

  assign any_out  = below_any | match;
  assign sel_data = at_target ? data : '0;

endmodule

// ===== src/ordered_list_store_core.sv =====
// Ordered list store: a row of slot cells driven by a five-step sequencer.
// The result is registered in the apply step, which follows the match, first-match and pick steps.
// A new command is taken only when idle, once match, first-match, pick and apply through the row are done.
// A waiting result does not block the next command until its apply step.
// Reset (rst, synchronous) clears the length and control; slot contents are not cleared.
// Depends on olst_pkg, olst_if and olst_cell.
module ordered_list_store_core #(
  parameter int CAPACITY   = olst_pkg::CAPACITY,
  parameter int ITEM_WIDTH = olst_pkg::ITEM_WIDTH
) (
  input logic           clk,
  input logic           rst,
  olst_cmd_if.sink      req,
  olst_res_if.source    rsp
);
  import olst_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;

  logic [2:0]            state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CMD_W-1:0]      cmd_r;
  logic [POS_W-1:0]      pos_r;
  logic [ITEM_WIDTH-1:0] item_r;
  logic [IDX_W-1:0]      target;
  logic                  pos_ok;
  logic                  hit;

  logic                  out_valid;
  logic [ITEM_WIDTH-1:0] out_value;
  logic [IDX_W-1:0]      out_found;
  logic [ST_W-1:0]       out_status;
  logic [CNT_W-1:0]      out_len;

  cell_ctrl_t            ctrl;
  logic [ITEM_WIDTH-1:0] cell_data [CAPACITY];
  logic [ITEM_WIDTH-1:0] sel_data  [CAPACITY];
  logic [CAPACITY:0]     any_chain;
  logic [CAPACITY-1:0]   first_vec;

  logic [PW-1:0]         pos_ext;
  logic [PW-1:0]         pos_adj;
  logic                  pos_in_range;
  logic [IDX_W-1:0]      enc;
  logic [ITEM_WIDTH-1:0] rd_data;
  logic                  out_free;
  logic                  apply_go;
  logic                  wr_req;
  logic                  shift_req;
  logic [ITEM_WIDTH-1:0] res_value;
  logic [IDX_W-1:0]      res_found;
  logic [ST_W-1:0]       res_status;

  assign req.ready = (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;
  assign apply_go  = (state == S_APPLY) && out_free;

  // cell row
  assign any_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0] above;
    if (i == CAPACITY - 1) begin : g_top
      assign above = cell_data[i];
    end else begin : g_mid
      assign above = cell_data[i+1];
    end

    olst_cell #(
      .ITEM_W(ITEM_WIDTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .target    (target),
      .count     (count),
      .item      (item_r),
      .above_data(above),
      .below_any (any_chain[i]),
      .data      (cell_data[i]),
      .sel_data  (sel_data[i]),
      .any_out   (any_chain[i+1]),
      .first     (first_vec[i])
    );
  end

  // position resolution: negative counts back from the tail
  always_comb begin
    pos_ext = {{(PW-POS_W){pos_r[POS_W-1]}}, pos_r};
    pos_adj = pos_r[POS_W-1] ? (pos_ext + PW'(count)) : pos_ext;
    pos_in_range = !pos_adj[PW-1] && (pos_adj < PW'(count));
  end

  // one-hot first match to index
  always_comb begin
    enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_vec[i]) enc = enc | IDX_W'(i);
    end
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | sel_data[i];
    end
  end

  always_comb begin
    wr_req     = 1'b0;
    shift_req  = 1'b0;
    res_value  = '0;
    res_found  = '0;
    res_status = ST_OK;
    count_next = count;
    case (cmd_r)
      CMD_APPEND: begin
        if (count == CNT_W'(CAPACITY)) begin
          res_status = ST_FULL;
        end else begin
          wr_req     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      CMD_POP: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_value  = rd_data;
          count_next = count - 1'b1;
        end
      end
      CMD_REMOVE_AT, CMD_READ, CMD_WRITE: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else if (!pos_ok) begin
          res_status = ST_RANGE;
        end else if (cmd_r == CMD_REMOVE_AT) begin
          res_value  = rd_data;
          shift_req  = 1'b1;
          count_next = count - 1'b1;
        end else if (cmd_r == CMD_READ) begin
          res_value = rd_data;
        end else begin
          wr_req = 1'b1;
        end
      end
      CMD_FIND, CMD_REMOVE_VAL: begin
        if (!hit) begin
          res_status = ST_MISSING;
        end else begin
          res_found = target;
          if (cmd_r == CMD_REMOVE_VAL) begin
            res_value  = rd_data;
            shift_req  = 1'b1;
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctrl.match_en = (state == S_MATCH);
    ctrl.first_en = (state == S_FIND);
    ctrl.wr_en    = apply_go && wr_req;
    ctrl.shift_en = apply_go && shift_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (apply_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) state <= S_MATCH;
        end
        S_MATCH: state <= S_FIND;
        S_FIND:  state <= S_PICK;
        S_PICK:  state <= S_APPLY;
        S_APPLY: begin
          if (out_free) begin
            count <= count_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      cmd_r  <= req.cmd;
      pos_r  <= req.position;
      item_r <= req.item_value;
    end
    if (state == S_MATCH) begin
      target <= pos_adj[IDX_W-1:0];
      pos_ok <= pos_in_range;
    end
    if (state == S_PICK) begin
      hit <= any_chain[CAPACITY] && (first_vec != '0);
      case (cmd_r)
        CMD_FIND, CMD_REMOVE_VAL: target <= enc;
        CMD_APPEND:               target <= count[IDX_W-1:0];
        CMD_POP:                  target <= IDX_W'(count - 1'b1);
        default:                  target <= target;
      endcase
    end
    if (apply_go) begin
      out_value  <= res_value;
      out_found  <= res_found;
      out_status <= res_status;
      out_len    <= count_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.result_value   = out_value;
  assign rsp.found_position = out_found;
  assign rsp.status         = out_status;
  assign rsp.list_length    = out_len;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_MATCH))
    else $error("accepted command did not start the match step");

  a_len_tracks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_len == count))
    else $error("reported length differs from held count");

  a_hit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && hit && (cmd_r == CMD_FIND || cmd_r == CMD_REMOVE_VAL))
      |-> (count != '0))
    else $error("match reported on an empty list");

  a_one_update: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.wr_en, ctrl.shift_en}))
    else $error("write and shift in the same cycle");

endmodule
